@@ src/ddo_pkg.sv @@
// Package for the differential-drive odometry block: payload types, constants
// and the CORDIC arctangent table. It depends on nothing else.
`timescale 1ns / 1ps
package ddo_pkg;

   localparam int CORDIC_STEPS  = 24;
   localparam int POS_FRAC_BITS = 16;
   localparam int STEP_W        = $clog2(CORDIC_STEPS + 1);

   localparam logic [31:0] KINV_Q30 = 32'd652032874;

   localparam logic [2:0] CSR_DIST_PER_PULSE = 3'd0;
   localparam logic [2:0] CSR_ANGLE_PER_MM   = 3'd1;
   localparam logic [2:0] CSR_START_X        = 3'd2;
   localparam logic [2:0] CSR_START_Y        = 3'd3;
   localparam logic [2:0] CSR_START_HEADING  = 3'd4;

   localparam logic [31:0] RST_DIST_PER_PULSE = 32'd623902;
   localparam logic [31:0] RST_ANGLE_PER_MM   = 32'd5258197;
   localparam logic [23:0] RST_START_X        = 24'd1200;
   localparam logic [23:0] RST_START_Y        = 24'd380;
   localparam logic [31:0] RST_START_HEADING  = 32'd1073741824;

   typedef struct packed {
      logic signed [31:0] right_count;
      logic signed [31:0] left_count;
   } req_type;

   typedef struct packed {
      logic signed [39:0] pos_x;
      logic signed [39:0] pos_y;
      logic [31:0]        heading;
      logic signed [31:0] step_x;
      logic signed [31:0] step_y;
      logic signed [31:0] step_angle;
   } rsp_type;

   // Count deltas handed from the front end to the back end.
   typedef struct packed {
      logic signed [32:0] sum;
      logic signed [32:0] diff;
   } delta_type;

   function automatic logic [31:0] atan_lookup(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0: r = 32'd536870912;   5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;   5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;    5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;    5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;     5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
            5'd20: r = 32'd652;        5'd21: r = 32'd326;
            5'd22: r = 32'd163;        5'd23: r = 32'd81;
            5'd24: r = 32'd41;         5'd25: r = 32'd20;
            5'd26: r = 32'd10;         5'd27: r = 32'd5;
            5'd28: r = 32'd3;          5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
         endcase
         return r;
      end
   endfunction

endpackage

@@ src/ddo_front.sv @@
// Front end: takes encoder samples, forms wrapped count deltas, keeps the
// last counts and pushes deltas into a two-entry queue. Uses ddo_pkg.
`timescale 1ns / 1ps
module ddo_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  ddo_pkg::req_type     req_data,
   output logic                 dq_valid,
   output ddo_pkg::delta_type   dq_data,
   input  logic                 dq_take
);

   logic [31:0] last_right_ff, last_right_in;
   logic [31:0] last_left_ff, last_left_in;
   ddo_pkg::delta_type q_ff [2];
   ddo_pkg::delta_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       acc;
   logic signed [31:0] dr, dl;
   ddo_pkg::delta_type d;

   assign req_full = (cnt_ff == 2'd2);
   assign acc      = req_push && !req_full;
   assign dq_valid = (cnt_ff != 2'd0);
   assign dq_data  = q_ff[0];

   always_comb begin
      dr = $signed(req_data.right_count - last_right_ff);
      dl = $signed(req_data.left_count - last_left_ff);
      d.sum  = 33'(dr) + 33'(dl);
      d.diff = 33'(dr) - 33'(dl);
      last_right_in = acc ? req_data.right_count : last_right_ff;
      last_left_in  = acc ? req_data.left_count  : last_left_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (dq_take && dq_valid) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (acc) begin
         q_in[cnt_in[0]] = d;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_right_ff <= '0;
         last_left_ff  <= '0;
         cnt_ff        <= '0;
      end else begin
         last_right_ff <= last_right_in;
         last_left_ff  <= last_left_in;
         cnt_ff        <= cnt_in;
      end
      q_ff <= q_in;
   end

endmodule

@@ src/ddo_back.sv @@
// Back end: sequencer that scales deltas with one shared 32x32 multiplier,
// runs the iterative CORDIC, updates the pose and fills the result register.
// Uses ddo_pkg.
`timescale 1ns / 1ps
module ddo_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 dq_valid,
   input  ddo_pkg::delta_type   dq_data,
   output logic                 dq_take,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output ddo_pkg::rsp_type     rsp_data
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_MSUM  = 9'b000000010,
      S_MDLO  = 9'b000000100,
      S_MAHI  = 9'b000001000,
      S_MALO  = 9'b000010000,
      S_CORD  = 9'b000100000,
      S_SCLO  = 9'b001000000,
      S_SCHI  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] dpp_ff, app_ff;
   logic [39:0] cur_x_ff, cur_y_ff;
   logic [31:0] cur_h_ff;
   logic signed [32:0] sum_ff, diff_ff;
   logic [63:0] lmag_ff;
   logic [31:0] dmag_hi_ff;     // upper bits of |diff|*dpp
   logic [31:0] dmag_lo_ff;
   logic [31:0] amag_ff;
   logic [31:0] da_ff;
   logic [1:0]  quad_ff;
   logic signed [32:0] cx_ff, cy_ff, cz_ff;
   logic [ddo_pkg::STEP_W-1:0] it_ff;
   logic        axis_ff;        // 0: x step, 1: y step
   logic [63:0] plo_ff;
   logic signed [31:0] sx_ff;
   logic        full_ff;
   ddo_pkg::rsp_type out_ff;

   // shared multiplier
   logic [31:0] ma, mb;
   logic [63:0] mp;
   assign mp = ma * mb;

   logic [31:0] smag, dabs;
   logic signed [32:0] c, s, t;
   logic [31:0] tm;
   logic        neg;
   logic [65:0] mag;
   logic signed [31:0] sat;
   logic [31:0] half, phi, rr;
   logic signed [32:0] xs, ys;
   logic [31:0] at;

   always_comb begin
      smag = sum_ff[32] ? 32'(-sum_ff) : 32'(sum_ff);
      dabs = diff_ff[32] ? 32'(-diff_ff) : 32'(diff_ff);
      case (quad_ff)
         2'd0: begin c = cx_ff;  s = cy_ff;  end
         2'd1: begin c = -cy_ff; s = cx_ff;  end
         2'd2: begin c = -cx_ff; s = -cy_ff; end
         default: begin c = cy_ff; s = -cx_ff; end
      endcase
      t  = axis_ff ? s : c;
      tm = t[32] ? 32'(-t) : 32'(t);
      neg = sum_ff[32] != t[32];
      ma = '0;
      mb = '0;
      case (state_ff)
         S_MSUM: begin ma = smag; mb = dpp_ff; end
         S_MDLO: begin ma = dabs; mb = dpp_ff; end
         S_MAHI: begin ma = dmag_hi_ff; mb = app_ff; end
         S_MALO: begin ma = dmag_lo_ff; mb = app_ff; end
         S_SCLO: begin ma = lmag_ff[31:0]; mb = tm; end
         S_SCHI: begin ma = lmag_ff[63:32]; mb = tm; end
         default: begin ma = '0; mb = '0; end
      endcase
      mag = {mp, 2'b00} + 66'(plo_ff >> 30);
      if (!neg)
         sat = (mag > 66'd2147483647) ? 32'h7FFFFFFF : mag[31:0];
      else
         sat = (mag >= 66'd2147483648) ? 32'h80000000 : 32'(-mag[31:0]);
      half = {da_ff[31], da_ff[31:1]};
      phi  = cur_h_ff + half;
      rr   = phi + 32'h20000000;
      xs   = cx_ff >>> it_ff;
      ys   = cy_ff >>> it_ff;
      at   = ddo_pkg::atan_lookup(5'(it_ff));
   end

   assign dq_take   = (state_ff == S_IDLE) && dq_valid && !full_ff;
   assign rsp_empty = !full_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (dq_take) state_in = S_MSUM;
         S_MSUM: state_in = S_MDLO;
         S_MDLO: state_in = S_MAHI;
         S_MAHI: state_in = S_MALO;
         S_MALO: state_in = S_CORD;
         S_CORD: if (32'(it_ff) == ddo_pkg::CORDIC_STEPS - 1) state_in = S_SCLO;
         S_SCLO: state_in = S_SCHI;
         S_SCHI: if (axis_ff) state_in = S_DONE; else state_in = S_SCLO;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         full_ff  <= 1'b0;
         dpp_ff   <= ddo_pkg::RST_DIST_PER_PULSE;
         app_ff   <= ddo_pkg::RST_ANGLE_PER_MM;
         cur_x_ff <= 40'($signed(ddo_pkg::RST_START_X)) << ddo_pkg::POS_FRAC_BITS;
         cur_y_ff <= 40'($signed(ddo_pkg::RST_START_Y)) << ddo_pkg::POS_FRAC_BITS;
         cur_h_ff <= ddo_pkg::RST_START_HEADING;
      end else begin
         state_ff <= state_in;
         if (rsp_pop && full_ff) full_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               ddo_pkg::CSR_DIST_PER_PULSE: dpp_ff <= csr_data;
               ddo_pkg::CSR_ANGLE_PER_MM:   app_ff <= csr_data;
               ddo_pkg::CSR_START_X:
                  cur_x_ff <= 40'($signed(csr_data[23:0])) << ddo_pkg::POS_FRAC_BITS;
               ddo_pkg::CSR_START_Y:
                  cur_y_ff <= 40'($signed(csr_data[23:0])) << ddo_pkg::POS_FRAC_BITS;
               ddo_pkg::CSR_START_HEADING:  cur_h_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (dq_take) begin
               sum_ff  <= dq_data.sum;
               diff_ff <= dq_data.diff;
            end
            // |sum| reaches 2^32 only when both wheels step by -2^31; the
            // 32-bit magnitude wraps to zero there, so take dpp * 2^32 directly
            S_MSUM: lmag_ff <= (sum_ff[32] && smag == 32'd0) ?
                               64'({dpp_ff, 32'd0} >> (33 - ddo_pkg::POS_FRAC_BITS)) :
                               64'(mp >> (33 - ddo_pkg::POS_FRAC_BITS));
            S_MDLO: begin
               dmag_hi_ff <= mp[63:32];
               dmag_lo_ff <= mp[31:0];
            end
            S_MAHI: amag_ff <= mp[31:0];
            S_MALO: begin
               da_ff <= diff_ff[32] ? -(amag_ff + mp[63:32]) : (amag_ff + mp[63:32]);
               it_ff <= '0;
            end
            S_CORD: begin
               if (it_ff == '0) begin
                  quad_ff <= rr[31:30];
                  // first iteration uses z from the reduced angle
                  if ($signed({3'b000, rr[29:0]}) - 33'sh20000000 >= 0) begin
                     cx_ff <= 33'(ddo_pkg::KINV_Q30);
                     cy_ff <= 33'(ddo_pkg::KINV_Q30);
                     cz_ff <= $signed({3'b000, rr[29:0]}) - 33'sh20000000
                              - 33'(at);
                  end else begin
                     cx_ff <= 33'(ddo_pkg::KINV_Q30);
                     cy_ff <= -33'(ddo_pkg::KINV_Q30);
                     cz_ff <= $signed({3'b000, rr[29:0]}) - 33'sh20000000
                              + 33'(at);
                  end
               end else if (!cz_ff[32]) begin
                  cx_ff <= cx_ff - ys;
                  cy_ff <= cy_ff + xs;
                  cz_ff <= cz_ff - 33'(at);
               end else begin
                  cx_ff <= cx_ff + ys;
                  cy_ff <= cy_ff - xs;
                  cz_ff <= cz_ff + 33'(at);
               end
               it_ff   <= it_ff + ddo_pkg::STEP_W'(1);
               axis_ff <= 1'b0;
            end
            S_SCLO: plo_ff <= mp;
            S_SCHI: begin
               if (!axis_ff) begin
                  sx_ff   <= sat;
                  axis_ff <= 1'b1;
               end else begin
                  out_ff.step_x <= sx_ff;
                  out_ff.step_y <= sat;
                  out_ff.pos_x  <= $signed(cur_x_ff + 40'(sx_ff));
                  out_ff.pos_y  <= $signed(cur_y_ff + 40'(sat));
                  out_ff.heading <= cur_h_ff + da_ff;
                  out_ff.step_angle <= $signed(da_ff);
                  cur_x_ff <= cur_x_ff + 40'(sx_ff);
                  cur_y_ff <= cur_y_ff + 40'(sat);
                  cur_h_ff <= cur_h_ff + da_ff;
               end
            end
            S_DONE: full_ff <= 1'b1;
            default: ;
         endcase
      end
   end

endmodule

@@ src/diff_drive_odometry.sv @@
// Differential-drive odometry, midpoint-arc pose update.
// Sequence from an accepted delta to rsp_empty falling: the take, 4 multiply
// steps, 24 CORDIC iterations, 4 scaling steps and the result load.
// The back-end sequencer handles one transaction at a time and waits for the
// result register to drain before it takes the next one.
// Reset (synchronous): registers take their defaults, pose loads from them,
// last counts clear, both queues empty.
`timescale 1ns / 1ps
module diff_drive_odometry (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  ddo_pkg::req_type     req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output ddo_pkg::rsp_type     rsp_data,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data
);

   logic               dq_valid, dq_take;
   ddo_pkg::delta_type dq_data;

   // front end: delta forming and a two-entry queue
   ddo_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .dq_valid, .dq_data, .dq_take
   );

   // back end: scaling, CORDIC, pose update, result register
   ddo_back u_back (
      .clock, .reset, .dq_valid, .dq_data, .dq_take,
      .csr_write, .csr_index, .csr_data,
      .rsp_empty, .rsp_pop, .rsp_data
   );

endmodule

@@ dv/ddo_checker.sv @@
// Pose checker for the differential-drive odometry block: watches the request,
// result and CSR ports, predicts each pose update and compares it. Needs ddo_pkg.
`timescale 1ns / 1ps
module ddo_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  ddo_pkg::req_type req_data,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  ddo_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data,
   output int               error_count,
   output int               pending_count
);

   localparam logic [31:0] ARCTAN [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1, 1, 0};

   logic [31:0] dist_per_pulse, angle_per_mm;
   logic [31:0] prev_right, prev_left, pose_heading;
   logic [39:0] pose_x, pose_y;
   ddo_pkg::rsp_type pose_queue[$];

   function automatic logic [39:0] start_to_q(input logic [23:0] whole);
      logic signed [39:0] wide;
      begin
         wide = signed'(whole);
         return wide << ddo_pkg::POS_FRAC_BITS;
      end
   endfunction

   // |L| times a Q2.30 trig value, saturated to 32 bits
   function automatic longint scale_step(input logic [63:0] lmag, input bit lneg,
                                         input longint t);
      logic [63:0] tm, lo, hi, mag;
      bit neg;
      begin
         neg = lneg != (t < 0);
         tm  = (t < 0) ? -t : t;
         lo  = {32'b0, lmag[31:0]} * tm;
         hi  = (lmag >> 32) * tm;
         mag = (hi << 2) + (lo >> 30);
         if (!neg) return (mag > 64'd2147483647) ? 2147483647 : longint'(mag);
         if (mag > 64'd2147483648) mag = 64'd2147483648;
         return -longint'(mag);
      end
   endfunction

   task automatic advance_pose(input ddo_pkg::req_type s, output ddo_pkg::rsp_type r);
      logic signed [31:0] d32;
      longint dr, dl, sum, diff, x, y, z, xs, ys, c, sn, sx, sy;
      logic [63:0] smag, dmag, lmag, amag;
      logic [31:0] da, half, phi, rr;
      begin
         d32 = s.right_count - prev_right;  dr = d32;
         d32 = s.left_count - prev_left;    dl = d32;
         prev_right = s.right_count;
         prev_left  = s.left_count;
         sum  = dr + dl;
         diff = dr - dl;
         smag = (sum < 0) ? -sum : sum;
         lmag = (smag * dist_per_pulse) >> (33 - ddo_pkg::POS_FRAC_BITS);
         dmag = ((diff < 0) ? -diff : diff) * dist_per_pulse;
         amag = (dmag >> 32) * angle_per_mm + (({32'b0, dmag[31:0]} * angle_per_mm) >> 32);
         da   = (diff < 0) ? -amag[31:0] : amag[31:0];
         half = {da[31], da[31:1]};
         phi  = pose_heading + half;
         rr   = phi + 32'h2000_0000;
         z    = rr[29:0];
         z    = z - 536870912;
         x    = ddo_pkg::KINV_Q30;
         y    = 0;
         for (int i = 0; i < ddo_pkg::CORDIC_STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys; y += xs; z -= ARCTAN[i];
            end else begin
               x += ys; y -= xs; z += ARCTAN[i];
            end
         end
         case (rr[31:30])
            2'd0: begin c = x;  sn = y;  end
            2'd1: begin c = -y; sn = x;  end
            2'd2: begin c = -x; sn = -y; end
            default: begin c = y; sn = -x; end
         endcase
         sx = scale_step(lmag, sum < 0, c);
         sy = scale_step(lmag, sum < 0, sn);
         pose_x       = pose_x + sx[39:0];
         pose_y       = pose_y + sy[39:0];
         pose_heading = pose_heading + da;
         r.pos_x      = pose_x;
         r.pos_y      = pose_y;
         r.heading    = pose_heading;
         r.step_x     = sx[31:0];
         r.step_y     = sy[31:0];
         r.step_angle = da;
      end
   endtask

   assign pending_count = pose_queue.size();

   always @(posedge clock) begin
      ddo_pkg::rsp_type want, got;
      if (reset) begin
         dist_per_pulse = ddo_pkg::RST_DIST_PER_PULSE;
         angle_per_mm   = ddo_pkg::RST_ANGLE_PER_MM;
         pose_x         = start_to_q(ddo_pkg::RST_START_X);
         pose_y         = start_to_q(ddo_pkg::RST_START_Y);
         pose_heading   = ddo_pkg::RST_START_HEADING;
         prev_right     = '0;
         prev_left      = '0;
         pose_queue.delete();
         error_count    = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               ddo_pkg::CSR_DIST_PER_PULSE: dist_per_pulse = csr_data;
               ddo_pkg::CSR_ANGLE_PER_MM:   angle_per_mm = csr_data;
               ddo_pkg::CSR_START_X:        pose_x = start_to_q(csr_data[23:0]);
               ddo_pkg::CSR_START_Y:        pose_y = start_to_q(csr_data[23:0]);
               ddo_pkg::CSR_START_HEADING:  pose_heading = csr_data;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            got = rsp_data;
            if (pose_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("unexpected result %h", got);
            end else begin
               want = pose_queue.pop_front();
               if (want.pos_x !== got.pos_x || want.pos_y !== got.pos_y ||
                   want.heading !== got.heading || want.step_x !== got.step_x ||
                   want.step_y !== got.step_y || want.step_angle !== got.step_angle) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: x %h/%h y %h/%h hd %h/%h sx %h/%h sy %h/%h da %h/%h",
                              want.pos_x, got.pos_x, want.pos_y, got.pos_y,
                              want.heading, got.heading, want.step_x, got.step_x,
                              want.step_y, got.step_y, want.step_angle, got.step_angle);
               end
            end
         end
         if (req_push && !req_full) begin
            advance_pose(req_data, want);
            pose_queue.push_back(want);
         end
      end
   end

endmodule

@@ dv/diff_drive_odometry_test.sv @@
// Testbench top for diff_drive_odometry: drives encoder samples and CSR writes
// and gives the verdict. Needs ddo_pkg, the block and ddo_checker.
`timescale 1ns / 1ps
module diff_drive_odometry_test;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;   // a bit over the block's latency

   logic             clock = 0;
   logic             reset = 1;
   logic             req_push = 0;
   logic             req_full;
   ddo_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 0;
   ddo_pkg::rsp_type rsp_data;
   logic             csr_write = 0;
   logic [2:0]       csr_index = '0;
   logic [31:0]      csr_data = '0;
   int               error_count, pending_count;

   // idle percentages per phase, read by the sender and the receiver
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_request = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   // running encoder counters
   logic [31:0] right_ctr = '0, left_ctr = '0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   diff_drive_odometry dut (.*);

   ddo_checker checker_i (.*);

   // Receiver: stall at random, and hold off for a long stretch on request
   // so the block backs up and asserts req_full.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = 600;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offer one sample; idle first at random, then hold until accepted.
   task automatic send_sample(input logic [31:0] r, input logic [31:0] l);
      begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
         req_push <= 1'b1;
         req_data <= '{right_count: r, left_count: l};
         @(posedge clock);
         while (req_full) @(posedge clock);
         right_ctr = r;
         left_ctr  = l;
      end
   endtask

   // Drop push and wait until every result is back, then let the pipe settle.
   task automatic drain;
      begin
         req_push <= 1'b0;
         @(posedge clock);
         while (pending_count != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      begin
         csr_write <= 1'b1;
         csr_index <= idx;
         csr_data  <= value;
         @(posedge clock);
         csr_write <= 1'b0;
      end
   endtask

   task automatic write_all(input logic [31:0] dpp, input logic [31:0] apm,
                            input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] hd);
      begin
         write_csr(ddo_pkg::CSR_DIST_PER_PULSE, dpp);
         write_csr(ddo_pkg::CSR_ANGLE_PER_MM, apm);
         write_csr(ddo_pkg::CSR_START_X, sx);
         write_csr(ddo_pkg::CSR_START_Y, sy);
         write_csr(ddo_pkg::CSR_START_HEADING, hd);
      end
   endtask

   // Mostly small wheel motion from the running counters; sometimes a jump
   // to arbitrary counter values so that every bit and the wrap get exercised.
   task automatic random_samples(input int n);
      logic [31:0] dr, dl;
      begin
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 75) begin
               dr = $urandom_range(4000) - 2000;
               dl = ($urandom_range(3) == 0) ? dr : dr + $urandom_range(600) - 300;
               send_sample(right_ctr + dr, left_ctr + dl);
            end else begin
               send_sample($urandom, $urandom);
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults, first sample against zero, extremes and wraps.
      send_sample(32'd0, 32'd0);
      send_sample(32'd1000, 32'd1000);
      send_sample(32'd1500, 32'd1000);
      send_sample(32'd1000, 32'd1500);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF);
      send_sample(32'h8000_0000, 32'h8000_0000);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'hFFFF_FFFF, 32'h0000_0000);
      send_sample(32'h0000_0000, 32'hFFFF_FFFF);
      send_sample(32'hFFFF_FF00, 32'hFFFF_FF00);
      send_sample(32'h0000_0100, 32'h0000_0100);
      drain();

      // Extremes of every register, including the largest start offsets and
      // writes to two unused indices, which must change nothing.
      write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0080_0000, 32'h007F_FFFF, 32'hFFFF_FFFF);
      write_csr(3'd5, 32'hDEAD_BEEF);
      write_csr(3'd7, 32'h1234_5678);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(32'h0000_0000, 32'h0000_0000);
      send_sample(32'h0000_0010, 32'h0000_0003);
      send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();
      write_all(32'd0, 32'd0, 32'h007F_FFFF, 32'hFF80_0000, 32'd0);
      send_sample(32'h1234_5678, 32'h8765_4321);
      send_sample(32'h0, 32'h0);
      drain();

      // Random phase, no idling, default-like scales.
      write_all(ddo_pkg::RST_DIST_PER_PULSE, ddo_pkg::RST_ANGLE_PER_MM,
                ddo_pkg::RST_START_X, ddo_pkg::RST_START_Y,
                ddo_pkg::RST_START_HEADING);
      random_samples(150);
      drain();

      // Sender idle most of the time, with large scales.
      send_idle_pct = 63;
      write_all($urandom, $urandom, $urandom, $urandom, $urandom);
      random_samples(150);
      drain();

      // Receiver stalling, and one long hold-off while the sender keeps going.
      send_idle_pct = 0;
      stall_pct = 63;
      write_all($urandom_range(2000000), $urandom_range(20000000), $urandom,
                $urandom, $urandom);
      hold_request = 1;
      random_samples(150);
      drain();

      // Both sides idling.
      send_idle_pct = 19;
      stall_pct = 19;
      write_all($urandom, $urandom_range(1000000), $urandom, $urandom, $urandom);
      random_samples(120);
      drain();

      // Back to full rate with fresh settings.
      send_idle_pct = 0;
      stall_pct = 0;
      write_all($urandom_range(4000000), $urandom, $urandom, $urandom, $urandom);
      random_samples(100);
      drain();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/ddo_pkg.sv
src/ddo_front.sv
src/ddo_back.sv
src/diff_drive_odometry.sv
dv/ddo_checker.sv
dv/diff_drive_odometry_test.sv
